/* hdl/tcr_pkg.sv */
// shared types, constants and helpers of the thick line coverage raster
`default_nettype none

package tcr_pkg;

  localparam int unsigned IMG_WIDTH_DEF  = 256;
  localparam int unsigned IMG_HEIGHT_DEF = 256;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned CRD_IN_W = 8;
  localparam int unsigned WID_W    = 4;
  localparam int unsigned COL_W    = 24;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned THR_W    = 9;

  // internal arithmetic widths
  localparam int unsigned CRD_W  = 16;
  localparam int unsigned SQ8_W  = 2 * CRD_IN_W;
  localparam int unsigned DSQ_W  = SQ8_W + 1;
  localparam int unsigned WSQ_W  = 2 * (WID_W + 1) - 1;
  localparam int unsigned DW_W   = DSQ_W + WSQ_W;
  localparam int unsigned SQ_W   = 2 * CRD_W;
  localparam int unsigned PROD_W = THR_W + CNT_W;
  localparam int unsigned FRAC_W = 8;

  localparam logic [COL_W-1:0] WHITE     = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(65536);
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(179);

  // command codes
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_MEASURE = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAW    = 2'd2;
  localparam logic [OP_W-1:0] OP_COUNT   = 2'd3;

  // datapath operations
  localparam int unsigned DPO_W = 4;
  localparam logic [DPO_W-1:0] DP_NOP    = 4'd0;
  localparam logic [DPO_W-1:0] DP_LOAD   = 4'd1;
  localparam logic [DPO_W-1:0] DP_SETUP1 = 4'd2;
  localparam logic [DPO_W-1:0] DP_SETUP2 = 4'd3;
  localparam logic [DPO_W-1:0] DP_SETUP3 = 4'd4;
  localparam logic [DPO_W-1:0] DP_SETUP4 = 4'd5;
  localparam logic [DPO_W-1:0] DP_A_INIT = 4'd6;
  localparam logic [DPO_W-1:0] DP_A_SKIP = 4'd7;
  localparam logic [DPO_W-1:0] DP_SQ     = 4'd8;
  localparam logic [DPO_W-1:0] DP_A_STEP = 4'd9;
  localparam logic [DPO_W-1:0] DP_A_EXIT = 4'd10;
  localparam logic [DPO_W-1:0] DP_B_INIT = 4'd11;
  localparam logic [DPO_W-1:0] DP_B_STEP = 4'd12;
  localparam logic [DPO_W-1:0] DP_B_EXIT = 4'd13;
  localparam logic [DPO_W-1:0] DP_FIN    = 4'd14;

  // which point a visit looks at
  localparam int unsigned VS_W = 2;
  localparam logic [VS_W-1:0] VS_MAIN = 2'd0;
  localparam logic [VS_W-1:0] VS_A    = 2'd1;
  localparam logic [VS_W-1:0] VS_B    = 2'd2;

  typedef struct packed {
    logic [DPO_W-1:0] op;
    logic [VS_W-1:0]  vsel;
    logic             mem_rd;
    logic             mem_wr;
    logic             sweep;
    logic             wr_zero;
    logic             vis_acc;
    logic             cnt_rd;
    logic             out_load;
  } tcr_cmd_t;

  typedef struct packed {
    logic a_br;
    logic b_br;
    logic in_w;
    logic a_more;
    logic b_more;
    logic x_done;
    logic y_done;
    logic vis_in;
    logic sweep_last;
  } tcr_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

/* hdl/tcr_ram.sv */
// generic single write, single registered read RAM
`default_nettype none

module tcr_ram
  import tcr_pkg::*;
#(
  parameter int unsigned WIDTH = COL_W,
  parameter int unsigned DEPTH = IMG_WIDTH_DEF * IMG_HEIGHT_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/tcr_dp.sv */
// datapath: line stepping registers, width test, image memory and counters
`default_nettype none

module tcr_dp
  import tcr_pkg::*;
#(
  parameter int unsigned IMG_WIDTH  = IMG_WIDTH_DEF,
  parameter int unsigned IMG_HEIGHT = IMG_HEIGHT_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tcr_cmd_t            cmd_i,
  output tcr_stat_t                stat_o,
  input  wire logic [CRD_IN_W-1:0] start_x_i,
  input  wire logic [CRD_IN_W-1:0] start_y_i,
  input  wire logic [CRD_IN_W-1:0] end_x_i,
  input  wire logic [CRD_IN_W-1:0] end_y_i,
  input  wire logic [WID_W-1:0]    line_width_i,
  input  wire logic [COL_W-1:0]    pixel_colour_i,
  input  wire logic                cfg_we_i,
  input  wire logic [THR_W-1:0]    cfg_data_i,
  output logic      [CNT_W-1:0]    visited_count_o,
  output logic      [CNT_W-1:0]    white_count_o,
  output logic                     covered_o
);

  localparam int unsigned DEPTH  = IMG_WIDTH * IMG_HEIGHT;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic signed [CRD_W-1:0] x0_q, y0_q, x1_q, y1_q, xs_q, ys_q;
  logic signed [CRD_W-1:0] dx_q, dy_q, sx_q, sy_q, err_q, e2_q;
  logic [WID_W-1:0]  width_q;
  logic [COL_W-1:0]  colour_q;
  logic [SQ8_W-1:0]  dxsq_q, dysq_q;
  logic [DSQ_W-1:0]  dsq_q;
  logic [WSQ_W-1:0]  wp1sq_q;
  logic [DW_W-1:0]   dw_q;
  logic [SQ_W-1:0]   sq_q;
  logic [PROD_W-1:0] prod_q;
  logic [CNT_W-1:0]  visits_q, whites_q;
  logic [THR_W-1:0]  thr_q;
  logic [ADDR_W-1:0] sweep_q;
  logic              cnt_chk_q;

  logic signed [CRD_W-1:0] dx_c, dy_c, vx, vy;
  logic signed [SQ_W-1:0]  e2sq;
  logic [DSQ_W-1:0]        dsum;
  logic [WID_W:0]          wp1;
  logic [ADDR_W-1:0]       vis_addr, mem_addr;
  logic [COL_W-1:0]        rdata;

  assign dx_c = (x1_q > x0_q) ? x1_q - x0_q : x0_q - x1_q;
  assign dy_c = (y1_q > y0_q) ? y1_q - y0_q : y0_q - y1_q;
  assign e2sq = e2_q * e2_q;
  assign dsum = DSQ_W'(dxsq_q) + DSQ_W'(dysq_q);
  assign wp1  = {1'b0, width_q} + (WID_W + 1)'(1);

  always_comb begin
    case (cmd_i.vsel)
      VS_A: begin
        vx = x0_q;
        vy = ys_q;
      end
      VS_B: begin
        vx = xs_q;
        vy = y0_q;
      end
      default: begin
        vx = x0_q;
        vy = y0_q;
      end
    endcase
  end

  assign vis_addr = ADDR_W'($unsigned(vy)) * ADDR_W'(IMG_WIDTH) + ADDR_W'($unsigned(vx));
  assign mem_addr = cmd_i.sweep ? sweep_q : vis_addr;

  assign stat_o.a_br   = (err_q <<< 1) >= -dx_q;
  assign stat_o.b_br   = (e2_q <<< 1) <= dy_q;
  // exact form of e2 < length * (w+1)/2
  assign stat_o.in_w   = e2_q[CRD_W-1] || ({sq_q, 2'b00} < (SQ_W + 2)'(dw_q));
  assign stat_o.a_more = (y1_q != ys_q) || (dx_q > dy_q);
  assign stat_o.b_more = (x1_q != xs_q) || (dx_q < dy_q);
  assign stat_o.x_done = (x0_q == x1_q);
  assign stat_o.y_done = (y0_q == y1_q);
  assign stat_o.vis_in = !vx[CRD_W-1] && !vy[CRD_W-1]
                      && ($unsigned(vx) < CRD_W'(IMG_WIDTH))
                      && ($unsigned(vy) < CRD_W'(IMG_HEIGHT));
  assign stat_o.sweep_last = (sweep_q == ADDR_W'(DEPTH - 1));

  tcr_ram #(
    .WIDTH(COL_W),
    .DEPTH(DEPTH)
  ) u_image (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mem_wr),
    .waddr_i(mem_addr),
    .wdata_i(cmd_i.wr_zero ? '0 : colour_q),
    .re_i   (cmd_i.mem_rd),
    .raddr_i(mem_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        x0_q     <= CRD_W'(start_x_i);
        y0_q     <= CRD_W'(start_y_i);
        x1_q     <= CRD_W'(end_x_i);
        y1_q     <= CRD_W'(end_y_i);
        width_q  <= line_width_i;
        colour_q <= pixel_colour_i;
      end
      DP_SETUP1: begin
        dx_q    <= dx_c;
        dy_q    <= dy_c;
        sx_q    <= (x0_q < x1_q) ? CRD_W'(1) : -CRD_W'(1);
        sy_q    <= (y0_q < y1_q) ? CRD_W'(1) : -CRD_W'(1);
        err_q   <= dx_c - dy_c;
        wp1sq_q <= WSQ_W'(wp1) * WSQ_W'(wp1);
      end
      DP_SETUP2: begin
        dxsq_q <= SQ8_W'(dx_q[CRD_IN_W-1:0]) * SQ8_W'(dx_q[CRD_IN_W-1:0]);
        dysq_q <= SQ8_W'(dy_q[CRD_IN_W-1:0]) * SQ8_W'(dy_q[CRD_IN_W-1:0]);
      end
      DP_SETUP3: begin
        // single point line counts as length one
        dsq_q <= (dsum == '0) ? DSQ_W'(1) : dsum;
      end
      DP_SETUP4: begin
        dw_q <= DW_W'(dsq_q) * DW_W'(wp1sq_q);
      end
      DP_A_INIT: begin
        xs_q <= x0_q;
        ys_q <= y0_q;
        e2_q <= err_q + dy_q;
      end
      DP_A_SKIP: begin
        xs_q <= x0_q;
        e2_q <= err_q;
      end
      DP_SQ: begin
        sq_q <= $unsigned(e2sq);
      end
      DP_A_STEP: begin
        ys_q <= ys_q + sy_q;
        e2_q <= e2_q + dx_q;
      end
      DP_A_EXIT: begin
        e2_q  <= err_q;
        err_q <= err_q - dy_q;
        x0_q  <= x0_q + sx_q;
      end
      DP_B_INIT: begin
        e2_q <= dx_q - e2_q;
      end
      DP_B_STEP: begin
        xs_q <= xs_q + sx_q;
        e2_q <= e2_q + dy_q;
      end
      DP_B_EXIT: begin
        err_q <= err_q + dx_q;
        y0_q  <= y0_q + sy_q;
      end
      DP_FIN: begin
        prod_q <= PROD_W'(thr_q) * PROD_W'(visits_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      visits_q <= '0;
      whites_q <= '0;
    end else if (cmd_i.vis_acc) begin
      visits_q <= sat_inc(visits_q);
      if (rdata == WHITE) begin
        whites_q <= sat_inc(whites_q);
      end
    end else if (cnt_chk_q && (rdata == colour_q)) begin
      visits_q <= sat_inc(visits_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      visited_count_o <= visits_q;
      white_count_o   <= whites_q;
      covered_o       <= (PROD_W'({whites_q, FRAC_W'(0)}) > prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_RESET;
      sweep_q   <= '0;
      cnt_chk_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.sweep) begin
        sweep_q <= (sweep_q == ADDR_W'(DEPTH - 1)) ? '0 : sweep_q + ADDR_W'(1);
      end
      cnt_chk_q <= cmd_i.cnt_rd;
    end
  end

endmodule

`default_nettype wire

/* hdl/tcr_ctrl.sv */
// controller state machine: sequences commands, line tracing and the output item
`default_nettype none

module tcr_ctrl
  import tcr_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [OP_W-1:0] operation_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire tcr_stat_t       stat_i,
  output tcr_cmd_t             cmd_o
);

  localparam int unsigned ST_W = 5;
  localparam logic [ST_W-1:0] S_CLR  = 5'd0;
  localparam logic [ST_W-1:0] S_IDLE = 5'd1;
  localparam logic [ST_W-1:0] S_SET1 = 5'd2;
  localparam logic [ST_W-1:0] S_SET2 = 5'd3;
  localparam logic [ST_W-1:0] S_SET3 = 5'd4;
  localparam logic [ST_W-1:0] S_SET4 = 5'd5;
  localparam logic [ST_W-1:0] S_VRD  = 5'd6;
  localparam logic [ST_W-1:0] S_VWB  = 5'd7;
  localparam logic [ST_W-1:0] S_A    = 5'd8;
  localparam logic [ST_W-1:0] S_ASQ  = 5'd9;
  localparam logic [ST_W-1:0] S_ACMP = 5'd10;
  localparam logic [ST_W-1:0] S_B    = 5'd11;
  localparam logic [ST_W-1:0] S_BSQ  = 5'd12;
  localparam logic [ST_W-1:0] S_BCMP = 5'd13;
  localparam logic [ST_W-1:0] S_WPIX = 5'd14;
  localparam logic [ST_W-1:0] S_CNT  = 5'd15;
  localparam logic [ST_W-1:0] S_CNTT = 5'd16;
  localparam logic [ST_W-1:0] S_FIN  = 5'd17;
  localparam logic [ST_W-1:0] S_OUT  = 5'd18;

  logic [ST_W-1:0] state_q, state_d;
  logic [VS_W-1:0] vis_q, vis_d;
  logic [OP_W-1:0] op_q, op_d;
  logic            out_valid_q, out_valid_d;
  logic [ST_W-1:0] ret_state;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // where a visit goes back to
  always_comb begin
    case (vis_q)
      VS_A:    ret_state = S_ASQ;
      VS_B:    ret_state = S_BSQ;
      default: ret_state = S_A;
    endcase
  end

  always_comb begin
    state_d = state_q;
    vis_d   = vis_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op   = DP_NOP;
    cmd_o.vsel = vis_q;

    case (state_q)
      S_CLR: begin
        cmd_o.sweep   = 1'b1;
        cmd_o.mem_wr  = 1'b1;
        cmd_o.wr_zero = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          op_d     = operation_i;
          case (operation_i)
            OP_WRITE: state_d = S_WPIX;
            OP_COUNT: state_d = S_CNT;
            default:  state_d = S_SET1;
          endcase
        end
      end
      S_WPIX: begin
        cmd_o.vsel   = VS_MAIN;
        cmd_o.mem_wr = stat_i.vis_in;
        state_d      = S_FIN;
      end
      S_CNT: begin
        cmd_o.sweep  = 1'b1;
        cmd_o.mem_rd = 1'b1;
        cmd_o.cnt_rd = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_CNTT;
        end
      end
      S_CNTT: begin
        state_d = S_FIN;
      end
      S_SET1: begin
        cmd_o.op = DP_SETUP1;
        state_d  = S_SET2;
      end
      S_SET2: begin
        cmd_o.op = DP_SETUP2;
        state_d  = S_SET3;
      end
      S_SET3: begin
        cmd_o.op = DP_SETUP3;
        state_d  = S_SET4;
      end
      S_SET4: begin
        cmd_o.op = DP_SETUP4;
        vis_d    = VS_MAIN;
        state_d  = S_VRD;
      end
      S_VRD: begin
        if (stat_i.vis_in) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = S_VWB;
        end else begin
          state_d = ret_state;
        end
      end
      S_VWB: begin
        cmd_o.vis_acc = 1'b1;
        cmd_o.mem_wr  = (op_q == OP_DRAW);
        state_d       = ret_state;
      end
      S_A: begin
        if (stat_i.a_br) begin
          cmd_o.op = DP_A_INIT;
          state_d  = S_ASQ;
        end else begin
          cmd_o.op = DP_A_SKIP;
          state_d  = S_B;
        end
      end
      S_ASQ: begin
        cmd_o.op = DP_SQ;
        state_d  = S_ACMP;
      end
      S_ACMP: begin
        if (stat_i.in_w && stat_i.a_more) begin
          cmd_o.op = DP_A_STEP;
          vis_d    = VS_A;
          state_d  = S_VRD;
        end else if (stat_i.x_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = DP_A_EXIT;
          state_d  = S_B;
        end
      end
      S_B: begin
        if (stat_i.b_br) begin
          cmd_o.op = DP_B_INIT;
          state_d  = S_BSQ;
        end else begin
          vis_d   = VS_MAIN;
          state_d = S_VRD;
        end
      end
      S_BSQ: begin
        cmd_o.op = DP_SQ;
        state_d  = S_BCMP;
      end
      S_BCMP: begin
        if (stat_i.in_w && stat_i.b_more) begin
          cmd_o.op = DP_B_STEP;
          vis_d    = VS_B;
          state_d  = S_VRD;
        end else if (stat_i.y_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = DP_B_EXIT;
          vis_d    = VS_MAIN;
          state_d  = S_VRD;
        end
      end
      S_FIN: begin
        cmd_o.op = DP_FIN;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      vis_q       <= VS_MAIN;
      op_q        <= OP_WRITE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vis_q       <= vis_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/thick_line_coverage_raster.sv */
// top level of the thick line coverage raster
`default_nettype none

// Image raster with thick line tracing and coverage measurement. After reset the
// block clears the image to black, one pixel a cycle, and takes no item until the
// whole image is cleared; configuration writes are taken at any time. Each item
// then runs on its own: a pixel write writes at most one pixel, a colour count
// reads every pixel once, and a measure or draw runs setup and finish steps plus,
// along the line, a read of each pixel visited inside the image (written back for
// a draw), a skip of each point that falls outside it, a squaring and compare for
// each width test of the stepping loops and the branch tests of each pass of the
// main stepping loop. The items share a single image memory. A finished result
// sits in an output register so the next item can be taken while it waits.
module thick_line_coverage_raster
  import tcr_pkg::*;
#(
  parameter int unsigned IMG_WIDTH  = IMG_WIDTH_DEF,
  parameter int unsigned IMG_HEIGHT = IMG_HEIGHT_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [OP_W-1:0]     operation_i,
  input  wire logic [CRD_IN_W-1:0] start_x_i,
  input  wire logic [CRD_IN_W-1:0] start_y_i,
  input  wire logic [CRD_IN_W-1:0] end_x_i,
  input  wire logic [CRD_IN_W-1:0] end_y_i,
  input  wire logic [WID_W-1:0]    line_width_i,
  input  wire logic [COL_W-1:0]    pixel_colour_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [CNT_W-1:0]    visited_count_o,
  output logic      [CNT_W-1:0]    white_count_o,
  output logic                     covered_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [THR_W-1:0]    cfg_data_i
);

  tcr_cmd_t  cmd;
  tcr_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .operation_i(operation_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tcr_dp #(
    .IMG_WIDTH (IMG_WIDTH),
    .IMG_HEIGHT(IMG_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .end_x_i        (end_x_i),
    .end_y_i        (end_y_i),
    .line_width_i   (line_width_i),
    .pixel_colour_i (pixel_colour_i),
    .cfg_we_i       (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .visited_count_o(visited_count_o),
    .white_count_o  (white_count_o),
    .covered_o      (covered_o)
  );

endmodule

`default_nettype wire
